### rtl/core/ordered_list_insert_delete_core_macros.svh
// ----------------------------------------------------------------------------
// Ordered list core assertion macros
// Shorthand for clocked assertions with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_MACROS_SVH

// Same-cycle implication.
`define OLID_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OLID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/olid_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Shared widths, request and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValW        = 32;
  localparam int unsigned ReqW        = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountW      = 5;
  localparam int unsigned PosW        = 4;

  localparam logic [ReqW-1:0] REQ_TAIL = 2'd0;
  localparam logic [ReqW-1:0] REQ_HEAD = 2'd1;
  localparam logic [ReqW-1:0] REQ_DEL  = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd3;

  // OP_SHL takes the right neighbor (gap close), OP_SHR the left (head insert).
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHL,
    OP_SHR
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage

### rtl/core/olid_if.sv
// ----------------------------------------------------------------------------
// Ordered list channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface olid_req_if;
  import olid_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ReqW-1:0]        req_type;
  logic signed [ValW-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface olid_rsp_if;
  import olid_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  count;
  logic [PosW-1:0]    removed_position;

  modport source (output valid, output status, output count, output removed_position,
                  input ready);
  modport sink   (input valid, input status, input count, input removed_position,
                  output ready);
endinterface

### rtl/core/olid_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry, compares it with the request value, and loads, holds or
// takes a neighbor's entry as the controller directs.
// ----------------------------------------------------------------------------
module olid_cell (
  input  logic                            clk_i,
  input  olid_pkg::cell_ctrl_t            ctrl_i,
  input  logic                            entry_valid_i,
  input  logic signed [olid_pkg::ValW-1:0] cmp_value_i,
  input  logic signed [olid_pkg::ValW-1:0] load_value_i,
  input  logic signed [olid_pkg::ValW-1:0] left_i,
  input  logic signed [olid_pkg::ValW-1:0] right_i,
  output logic signed [olid_pkg::ValW-1:0] data_o,
  output logic                            hit_o
);
  import olid_pkg::*;

  logic signed [ValW-1:0] data_q, data_d;
  logic                   hit_q;

  always_comb begin
    case (ctrl_i.op)
      OP_LOAD: data_d = load_value_i;
      OP_SHL:  data_d = right_i;
      OP_SHR:  data_d = left_i;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctrl_i.cmp_en) begin
      hit_q <= entry_valid_i && (data_q == cmp_value_i);
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

### rtl/core/ordered_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// Ordered list insert/delete core
// Bounded ordered list with head insert, tail insert and first-match delete.
// ----------------------------------------------------------------------------
// Every request yields one response. On acceptance each cell compares its
// entry with the request value into a registered hit; on execution the first
// match is picked from the hit vector and the list moves in a single step
// (head insert shifts all cells, delete those from the match on). Execution
// waits for a drained response register, and no request is taken until it
// ends; one is accepted while the previous response still waits to be taken.
module ordered_list_insert_delete_core #(
  parameter int unsigned CAPACITY = olid_pkg::DefCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  olid_req_if.sink   req,
  olid_rsp_if.source rsp
);
  import olid_pkg::*;

  `include "ordered_list_insert_delete_core_macros.svh"

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        count_q;
  logic [ReqW-1:0]        req_q;
  logic signed [ValW-1:0] value_q;

  logic                   rsp_valid_q;
  logic [StatusW-1:0]     status_q;
  logic [CountW-1:0]      rsp_count_q;
  logic [PosW-1:0]        pos_q;

  cell_ctrl_t             ctrl   [CAPACITY];
  logic signed [ValW-1:0] data   [CAPACITY];
  logic [CAPACITY-1:0]    hits;
  logic [CAPACITY-1:0]    below, first;
  logic [IdxW-1:0]        hit_pos;
  logic                   any_hit;
  logic                   full;
  logic                   accept, exec_fire;
  logic [StatusW-1:0]     status_d;
  logic [CntW-1:0]        count_d;
  logic [IdxW-1:0]        pos_d;

  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign exec_fire = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
  assign full      = (count_q == CntW'(CAPACITY));

  // First match from the head: bits strictly below the lowest hit, then the
  // lowest hit itself. Cells at and above it close the gap.
  assign below   = (hits - CAPACITY'(1)) & ~hits;
  assign first   = hits & ~(hits - CAPACITY'(1));
  assign any_hit = |hits;

  always_comb begin
    hit_pos = '0;
    for (int b = 0; b < IdxW; b++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (((i >> b) & 1) == 1) begin
          hit_pos[b] = hit_pos[b] | first[i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].cmp_en = accept;
      ctrl[i].op     = OP_HOLD;
      if (exec_fire) begin
        case (req_q)
          REQ_TAIL: if (!full && (count_q == CntW'(i))) ctrl[i].op = OP_LOAD;
          REQ_HEAD: if (!full) ctrl[i].op = (i == 0) ? OP_LOAD : OP_SHR;
          REQ_DEL:  if (any_hit && !below[i]) ctrl[i].op = OP_SHL;
          default:  ctrl[i].op = OP_HOLD;
        endcase
      end
    end
  end

  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    pos_d    = '0;
    case (req_q)
      REQ_TAIL, REQ_HEAD: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      REQ_DEL: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (any_hit) begin
          count_d = count_q - CntW'(1);
          pos_d   = hit_pos;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ValW-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = value_q;
    end else begin : g_mid
      assign left_w = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = data[g];
    end else begin : g_inner
      assign right_w = data[g+1];
    end

    olid_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl[g]),
      .entry_valid_i (CntW'(g) < count_q),
      .cmp_value_i   (req.value),
      .load_value_i  (value_q),
      .left_i        (left_w),
      .right_i       (right_w),
      .data_o        (data[g]),
      .hit_o         (hits[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= ST_OK;
      rsp_count_q <= '0;
      pos_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (accept) state_q <= S_EXEC;
        S_EXEC: if (exec_fire) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (exec_fire) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
        status_q    <= status_d;
        rsp_count_q <= CountW'(count_d);
        pos_q       <= PosW'(pos_d);
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req.req_type;
      value_q <= req.value;
    end
  end

  assign rsp.valid            = rsp_valid_q;
  assign rsp.status           = status_q;
  assign rsp.count            = rsp_count_q;
  assign rsp.removed_position = pos_q;

  `OLID_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(CAPACITY),
                    "entry count exceeds capacity")
  `OLID_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, accept, state_q == S_EXEC,
                    "accepted transaction did not enter execution")
  `OLID_ASSERT_IMPL(a_rsp_from_exec, clk_i, rst_ni, $rose(rsp_valid_q),
                    $past(state_q == S_EXEC), "response raised without execution")
  `OLID_ASSERT_NEXT(a_full_hold, clk_i, rst_ni,
                    exec_fire && full && (req_q == REQ_TAIL || req_q == REQ_HEAD),
                    count_q == CntW'(CAPACITY), "full insert changed the count")

endmodule
